// ----- hdl/ple_pkg.sv -----
package ple_pkg;

    localparam int CAPACITY = 256;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int GROUP    = 16;
    localparam int NGROUPS  = (CAPACITY + GROUP - 1) / GROUP;
    localparam int NCELLS   = NGROUPS * GROUP;

    localparam int DATA_W   = 32;
    localparam int POS_W    = 10;
    localparam int LEN_W    = 9;
    localparam int STATUS_W = 2;
    localparam int OP_W     = 3;
    localparam int CMP_W    = (CNT_W > POS_W - 1) ? CNT_W : POS_W - 1;

    localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_GET    = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;
    localparam logic [OP_W-1:0] OP_FIND   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef enum logic [1:0] {
        SHIFT_NONE = 2'd0,
        SHIFT_INS  = 2'd1,
        SHIFT_REM  = 2'd2
    } shift_t;

    typedef struct packed {
        shift_t             shift;
        logic [CNT_W-1:0]   at;
        logic [DATA_W-1:0]  value;
        logic               get_en;
        logic               find_en;
        logic [CNT_W-1:0]   count;
    } cell_cmd_t;

    typedef struct packed {
        logic               hit;
        logic [DATA_W-1:0]  data;
    } cell_rsp_t;

endpackage

// ----- hdl/ple_cell.sv -----
module ple_cell
    import ple_pkg::*;
(
    input  logic              clk,
    input  logic [CNT_W-1:0]  idx,
    input  cell_cmd_t         cmd,
    input  logic [DATA_W-1:0] left_q,
    input  logic [DATA_W-1:0] right_q,
    output logic [DATA_W-1:0] q,
    output cell_rsp_t         rsp
);

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;
    logic              hit;

    always_comb
    begin
        entry_next = entry_reg;
        unique case (cmd.shift)
            SHIFT_INS:
            begin
                if (idx > cmd.at)
                begin
                    entry_next = left_q;
                end
                else if (idx == cmd.at)
                begin
                    entry_next = cmd.value;
                end
            end
            SHIFT_REM:
            begin
                if (idx >= cmd.at)
                begin
                    entry_next = right_q;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_comb
    begin
        hit = (cmd.get_en && (idx == cmd.at))
            || (cmd.find_en && (idx < cmd.count) && (entry_reg == cmd.value));
        rsp.hit  = hit;
        rsp.data = hit ? entry_reg : '0;
    end

    assign q = entry_reg;

endmodule

// ----- hdl/ple_group.sv -----
module ple_group
    import ple_pkg::*;
(
    input  logic      clk,
    input  logic      load,
    input  cell_rsp_t rsp_in [GROUP],
    output cell_rsp_t rsp_out
);

    cell_rsp_t sum_reg;
    cell_rsp_t sum_next;

    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < GROUP; k++)
        begin
            sum_next.hit  = sum_next.hit | rsp_in[k].hit;
            sum_next.data = sum_next.data | rsp_in[k].data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_reg <= sum_next;
        end
    end

    assign rsp_out = sum_reg;

endmodule

// ----- hdl/positional_list_engine_unit.sv -----
// positional list engine: an ordered list of signed 32-bit entries held in a
// row of cells, one entry per cell, with a length count
// request channel: req_valid / req_stall with operation, value, position
// response channel: rsp_valid / rsp_stall with status, read_value, length
// every request word gives exactly one response word, in order
// requests pass an in-flight stage and a response register; one request per
// cycle sustained while the response side does not stall; insert and remove
// shift cells from the position onward by one in the accept cycle; get/find
// use a two-level registered or-tree (groups of 16 cells, then the groups)
// reset clears the length and the pipeline valids; cell contents are not
// cleared and never read beyond the length
// a stalled response word holds; the request side stalls once the
// in-flight stage is also full
module positional_list_engine_unit
    import ple_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [OP_W-1:0]     operation,
    input  logic signed [DATA_W-1:0] value,
    input  logic signed [POS_W-1:0]  position,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [STATUS_W-1:0] status,
    output logic signed [DATA_W-1:0] read_value,
    output logic [LEN_W-1:0]    length
);

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    logic                s1_valid_reg;
    logic                s1_find_reg;
    logic                s1_get_reg;
    logic [STATUS_W-1:0] s1_status_reg;
    logic [CNT_W-1:0]    s1_len_reg;

    logic                rsp_valid_reg;
    logic [STATUS_W-1:0] rsp_status_reg;
    logic [DATA_W-1:0]   rsp_data_reg;
    logic [CNT_W-1:0]    rsp_len_reg;

    logic                accept;
    logic                s1_adv;
    logic                neg;
    logic [CMP_W-1:0]    pos_mag;
    logic [CMP_W-1:0]    cnt_ext;
    logic                in_range;
    logic                past_end;
    logic                full;
    logic [CNT_W-1:0]    ins_at;
    logic [STATUS_W-1:0] base_status;
    logic                is_find;
    logic                is_get;
    cell_cmd_t           cmd;

    logic [DATA_W-1:0]   cell_q   [NCELLS];
    cell_rsp_t           cell_rsp [NCELLS];
    cell_rsp_t           grp_rsp  [NGROUPS];
    cell_rsp_t           tree_sum;

    assign s1_adv    = s1_valid_reg && !(rsp_valid_reg && rsp_stall);
    assign req_stall = s1_valid_reg && !s1_adv;
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        neg      = position[POS_W-1];
        pos_mag  = CMP_W'(position[POS_W-2:0]);
        cnt_ext  = CMP_W'(count_reg);
        in_range = !neg && (pos_mag < cnt_ext);
        past_end = pos_mag >= cnt_ext;
        full     = (count_reg == CNT_W'(CAPACITY));
        if (neg)
        begin
            ins_at = '0;
        end
        else if (past_end)
        begin
            ins_at = count_reg;
        end
        else
        begin
            ins_at = CNT_W'(pos_mag);
        end

        cmd         = '0;
        cmd.shift   = SHIFT_NONE;
        cmd.value   = value;
        cmd.count   = count_reg;
        count_next  = count_reg;
        base_status = ST_MISS;
        is_find     = 1'b0;
        is_get      = 1'b0;

        unique case (operation)
            OP_APPEND:
            begin
                if (full)
                begin
                    base_status = ST_FULL;
                end
                else
                begin
                    cmd.shift   = SHIFT_INS;
                    cmd.at      = count_reg;
                    count_next  = count_reg + CNT_W'(1);
                    base_status = ST_OK;
                end
            end
            OP_INSERT:
            begin
                if (full)
                begin
                    base_status = ST_FULL;
                end
                else
                begin
                    cmd.shift   = SHIFT_INS;
                    cmd.at      = ins_at;
                    count_next  = count_reg + CNT_W'(1);
                    base_status = ST_OK;
                end
            end
            OP_GET:
            begin
                if (in_range)
                begin
                    cmd.get_en  = 1'b1;
                    cmd.at      = CNT_W'(pos_mag);
                    is_get      = 1'b1;
                    base_status = ST_OK;
                end
            end
            OP_REMOVE:
            begin
                if (in_range)
                begin
                    cmd.shift   = SHIFT_REM;
                    cmd.at      = CNT_W'(pos_mag);
                    count_next  = count_reg - CNT_W'(1);
                    base_status = ST_OK;
                end
            end
            OP_CLEAR:
            begin
                count_next  = '0;
                base_status = ST_OK;
            end
            OP_FIND:
            begin
                cmd.find_en = 1'b1;
                is_find     = 1'b1;
            end
            default:
            begin
                base_status = ST_MISS;
            end
        endcase

        if (!accept)
        begin
            cmd.shift  = SHIFT_NONE;
            count_next = count_reg;
        end
    end

    // cell row
    generate
        for (genvar i = 0; i < NCELLS; i++)
        begin : g_cell
            if (i < CAPACITY)
            begin : g_live
                logic [DATA_W-1:0] left_q;
                logic [DATA_W-1:0] right_q;
                if (i == 0)
                begin : g_first
                    assign left_q = value;
                end
                else
                begin : g_mid
                    assign left_q = cell_q[i-1];
                end
                if (i == CAPACITY - 1)
                begin : g_last
                    assign right_q = '0;
                end
                else
                begin : g_next
                    assign right_q = cell_q[i+1];
                end
                ple_cell u_cell (
                    .clk     (clk),
                    .idx     (CNT_W'(i)),
                    .cmd     (cmd),
                    .left_q  (left_q),
                    .right_q (right_q),
                    .q       (cell_q[i]),
                    .rsp     (cell_rsp[i])
                );
            end
            else
            begin : g_pad
                assign cell_q[i]   = '0;
                assign cell_rsp[i] = '0;
            end
        end

        for (genvar g = 0; g < NGROUPS; g++)
        begin : g_grp
            ple_group u_group (
                .clk     (clk),
                .load    (accept),
                .rsp_in  (cell_rsp[g*GROUP +: GROUP]),
                .rsp_out (grp_rsp[g])
            );
        end
    endgenerate

    always_comb
    begin
        tree_sum = '0;
        for (int g = 0; g < NGROUPS; g++)
        begin
            tree_sum.hit  = tree_sum.hit | grp_rsp[g].hit;
            tree_sum.data = tree_sum.data | grp_rsp[g].data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_find_reg   <= is_find;
            s1_get_reg    <= is_get;
            s1_status_reg <= base_status;
            s1_len_reg    <= count_next;
        end
        if (s1_adv)
        begin
            if (s1_find_reg)
            begin
                rsp_status_reg <= tree_sum.hit ? ST_OK : ST_MISS;
            end
            else
            begin
                rsp_status_reg <= s1_status_reg;
            end
            rsp_data_reg <= s1_get_reg ? tree_sum.data : '0;
            rsp_len_reg  <= s1_len_reg;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign status     = rsp_status_reg;
    assign read_value = rsp_data_reg;
    assign length     = LEN_W'(rsp_len_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("length above capacity");

    a_stall_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> s1_valid_reg)
        else $error("request stalled with empty pipeline");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == OP_CLEAR) |=> (count_reg == '0))
        else $error("clear left entries");

    a_rsp_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_stall && !s1_valid_reg) |=> !rsp_valid)
        else $error("response word repeated");

    a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !rsp_valid) |=> rsp_valid)
        else $error("in-flight word not forwarded");

endmodule

// ----- bench/testbench.sv -----
module testbench;
    import ple_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;
    localparam int IDLE_PCT     = 37;
    localparam int RANDOM_WORDS = 1400;
    localparam int MIX_WORDS    = 60;
    localparam int FULL_EXTRA   = 20;
    localparam int DRAIN_FLOOR  = 64;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   read_value;
        logic [LEN_W-1:0]    length;
    } list_answer_t;

    typedef enum {MIX_ROUND, FILL_ROUND, DRAIN_ROUND} round_kind_t;

    class list_scoreboard;
        logic [DATA_W-1:0] shadow_list[$];
        list_answer_t      expected_answers[$];
        int                mismatches = 0;

        function void flag(list_answer_t want, list_answer_t got, string what);
            mismatches++;
            if (mismatches <= 10)
                $display({"%s: expected status %0d read_value %h length %0d,",
                          " got status %0d read_value %h length %0d"},
                         what, want.status, want.read_value, want.length,
                         got.status, got.read_value, got.length);
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [DATA_W-1:0] val,
                                   logic signed [POS_W-1:0] pos);
            list_answer_t answer;
            int p;
            int n;
            int at;
            p = pos;
            n = shadow_list.size();
            answer.status = ST_MISS;
            answer.read_value = '0;
            case (op)
                OP_APPEND:
                    if (n >= CAPACITY)
                        answer.status = ST_FULL;
                    else
                    begin
                        shadow_list.push_back(val);
                        answer.status = ST_OK;
                    end
                OP_INSERT:
                    if (n >= CAPACITY)
                        answer.status = ST_FULL;
                    else
                    begin
                        if (p <= 0 || n == 0)
                            at = 0;
                        else if (p >= n)
                            at = n;
                        else
                            at = p;
                        shadow_list.insert(at, val);
                        answer.status = ST_OK;
                    end
                OP_GET:
                    if (p >= 0 && p < n)
                    begin
                        answer.read_value = shadow_list[p];
                        answer.status = ST_OK;
                    end
                OP_REMOVE:
                    if (p >= 0 && p < n)
                    begin
                        shadow_list.delete(p);
                        answer.status = ST_OK;
                    end
                OP_CLEAR:
                begin
                    shadow_list.delete();
                    answer.status = ST_OK;
                end
                OP_FIND:
                    foreach (shadow_list[i])
                        if (shadow_list[i] == val)
                            answer.status = ST_OK;
                default: ;
            endcase
            answer.length = LEN_W'(shadow_list.size());
            expected_answers.push_back(answer);
        endfunction

        function void check_answer(list_answer_t got);
            list_answer_t want;
            if (expected_answers.size() == 0)
            begin
                want = '0;
                flag(want, got, "unexpected word");
            end
            else
            begin
                want = expected_answers.pop_front();
                if (got.status !== want.status || got.read_value !== want.read_value
                    || got.length !== want.length)
                    flag(want, got, "mismatch");
            end
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        req_valid = 1'b0;
    logic                        req_stall;
    logic [OP_W-1:0]             operation = OP_CLEAR;
    logic signed [DATA_W-1:0]    value = '0;
    logic signed [POS_W-1:0]     position = '0;
    logic                        rsp_valid;
    logic                        rsp_stall = 1'b0;
    logic [STATUS_W-1:0]         status;
    logic signed [DATA_W-1:0]    read_value;
    logic [LEN_W-1:0]            length;

    logic steady = 1'b0;
    int   random_sent = 0;

    list_scoreboard scoreboard = new();

    positional_list_engine_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .operation  (operation),
        .value      (value),
        .position   (position),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .status     (status),
        .read_value (read_value),
        .length     (length)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

    always @(negedge clk)
        rsp_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);

    always @(posedge clk)
    begin : watch_answers
        list_answer_t got;
        got.status = status;
        got.read_value = read_value;
        got.length = length;
        if (rst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0)
            scoreboard.check_answer(got);
    end

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_word(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val,
                             input logic signed [POS_W-1:0] pos);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        operation <= op;
        value <= val;
        position <= pos;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
        scoreboard.note_request(op, val, pos);
        @(negedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_value(int n);
        int r;
        r = $urandom_range(0, 99);
        if (n > 0 && r < 30)
            return scoreboard.shadow_list[$urandom_range(0, n - 1)];
        if (r < 40)
            case ($urandom_range(0, 3))
                0: return 32'h0000_0000;
                1: return 32'hFFFF_FFFF;
                2: return 32'h7FFF_FFFF;
                default: return 32'h8000_0000;
            endcase
        return $urandom();
    endfunction

    function automatic logic signed [POS_W-1:0] pick_position(int n);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return POS_W'($urandom_range(0, n));
        if (r < 80)
            return -10'sd1;
        if (r < 90)
            return 10'sd256;
        return POS_W'($urandom_range(0, 1023));
    endfunction

    function automatic logic [OP_W-1:0] pick_op(round_kind_t kind);
        int r;
        r = $urandom_range(0, 99);
        case (kind)
            FILL_ROUND:
                if (r < 45) return OP_APPEND;
                else if (r < 90) return OP_INSERT;
                else if (r < 94) return OP_GET;
                else if (r < 98) return OP_FIND;
                else return OP_REMOVE;
            DRAIN_ROUND:
                if (r < 85) return OP_REMOVE;
                else if (r < 90) return OP_GET;
                else if (r < 95) return OP_FIND;
                else if (r < 98) return OP_APPEND;
                else return OP_INSERT;
            default:
                if (r < 20) return OP_APPEND;
                else if (r < 40) return OP_INSERT;
                else if (r < 57) return OP_GET;
                else if (r < 75) return OP_REMOVE;
                else if (r < 92) return OP_FIND;
                else if (r < 95) return OP_CLEAR;
                else if (r < 97) return OP_SPARE6;
                else return OP_SPARE7;
        endcase
    endfunction

    task automatic random_word(input round_kind_t kind);
        int n;
        logic [OP_W-1:0] op;
        logic signed [POS_W-1:0] pos;
        n = scoreboard.shadow_list.size();
        op = pick_op(kind);
        if (kind == DRAIN_ROUND && op == OP_REMOVE && n > 0 && $urandom_range(0, 9) != 0)
            pos = POS_W'($urandom_range(0, n - 1));
        else
            pos = pick_position(n);
        send_word(op, pick_value(n), pos);
        random_sent++;
    endtask

    initial
    begin : main_flow
        int round;
        int extra;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty list
        send_word(OP_GET, 32'h0, 10'sd0);
        send_word(OP_REMOVE, 32'h0, 10'sd0);
        send_word(OP_FIND, 32'h0, 10'sd0);
        // inserts at front, middle and past the end
        send_word(OP_INSERT, 32'h0000_0001, 10'sd5);
        send_word(OP_APPEND, 32'h7FFF_FFFF, 10'sd0);
        send_word(OP_APPEND, 32'h8000_0000, 10'sd0);
        send_word(OP_INSERT, 32'h0000_0000, -10'sd1);
        send_word(OP_INSERT, 32'hFFFF_FFFF, 10'sd1);
        send_word(OP_INSERT, 32'h1234_5678, 10'sd256);
        send_word(OP_INSERT, 32'h5555_5555, 10'sh200);
        send_word(OP_INSERT, 32'hAAAA_AAAA, 10'sd511);
        // reads and removes at the bounds, spare operation codes, clear
        send_word(OP_GET, 32'h0, -10'sd1);
        send_word(OP_GET, 32'h0, 10'sd0);
        send_word(OP_GET, 32'h0, 10'sd7);
        send_word(OP_GET, 32'h0, 10'sd8);
        send_word(OP_FIND, 32'h8000_0000, 10'sd0);
        send_word(OP_FIND, 32'h0000_0002, 10'sd0);
        send_word(OP_REMOVE, 32'h0, 10'sd0);
        send_word(OP_REMOVE, 32'h0, 10'sd3);
        send_word(OP_REMOVE, 32'h0, 10'sd256);
        send_word(OP_REMOVE, 32'h0, -10'sd1);
        send_word(OP_SPARE6, 32'hFFFF_FFFF, 10'sd0);
        send_word(OP_SPARE7, 32'h0, 10'sd0);
        send_word(OP_CLEAR, 32'h0, 10'sd0);
        send_word(OP_GET, 32'h0, 10'sd0);
        send_word(OP_CLEAR, 32'h0, 10'sd0);

        round = 0;
        while (random_sent < RANDOM_WORDS)
        begin
            steady = (round == 1);
            case (round % 3)
                0:
                    repeat (MIX_WORDS) random_word(MIX_ROUND);
                1:
                begin
                    extra = 0;
                    while (extra < FULL_EXTRA)
                    begin
                        if (scoreboard.shadow_list.size() >= CAPACITY)
                            extra++;
                        random_word(FILL_ROUND);
                    end
                end
                default:
                begin
                    while (scoreboard.shadow_list.size() > DRAIN_FLOOR)
                        random_word(DRAIN_ROUND);
                    send_word(OP_CLEAR, $urandom(), POS_W'($urandom_range(0, 1023)));
                end
            endcase
            round++;
        end
        steady = 1'b0;
        req_valid <= 1'b0;

        while (scoreboard.expected_answers.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (scoreboard.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/ple_pkg.sv
hdl/ple_cell.sv
hdl/ple_group.sv
hdl/positional_list_engine_unit.sv
bench/testbench.sv
